[hw/rtl/circular_deque_top_assert.svh]
// Assertion macros shared by the deque checker.
`ifndef CIRCULAR_DEQUE_TOP_ASSERT_SVH
`define CIRCULAR_DEQUE_TOP_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define CDQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error(msg);

`endif

[hw/rtl/cdq_pkg.sv]
`default_nettype none
package cdq_pkg;

   // Queue geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int WORD_W = 32;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_REAR  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_REAR   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                   command;
      logic signed [WORD_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]  popped_value;
      status_type                status;
      logic                      is_empty;
      logic                      is_full;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic respond;
   } ctrl_type;

endpackage
`default_nettype wire

[hw/rtl/cdq_datapath.sv]
`default_nettype none
module cdq_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cdq_pkg::ctrl_type ctrl,
   input  wire cdq_pkg::req_type  req_data,
   output cdq_pkg::rsp_type       rsp_data
);
   import cdq_pkg::*;

   typedef logic [IDX_W-1:0] idx_type;

   // Step an index forward or back around the ends of the store.
   function automatic idx_type wrap_next(input idx_type i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic idx_type wrap_prev(input idx_type i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
   endfunction

   cmd_type                  cmd_ff;
   logic signed [WORD_W-1:0] val_ff;
   idx_type                  front_ff, front_in;
   idx_type                  rear_ff, rear_in;
   logic                     empty_ff, empty_in;
   status_type               status_ff, status_in;
   logic                     pop_ok_ff, pop_ok_in;
   logic signed [WORD_W-1:0] rdata_ff;
   logic signed [WORD_W-1:0] mem [DEPTH];

   idx_type slot;
   logic    wr_en;
   logic    rd_en;
   logic    full_now;

   // Capture the command on transfer
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= req_data.command;
         val_ff <= req_data.value;
      end
   end

   assign full_now = !empty_ff && (wrap_next(rear_ff) == front_ff);

   // Decide the step and the next pointer values
   always_comb begin
      front_in  = front_ff;
      rear_in   = rear_ff;
      empty_in  = empty_ff;
      status_in = STATUS_DONE;
      pop_ok_in = 1'b0;
      slot      = '0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      unique case (cmd_ff) inside
         CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            if (full_now) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en = 1'b1;
               if (empty_ff) begin
                  // first entry lands at slot zero
                  front_in = '0;
                  rear_in  = '0;
                  empty_in = 1'b0;
                  slot     = '0;
               end else if (cmd_ff == CMD_PUSH_FRONT) begin
                  front_in = wrap_prev(front_ff);
                  slot     = wrap_prev(front_ff);
               end else begin
                  rear_in = wrap_next(rear_ff);
                  slot    = wrap_next(rear_ff);
               end
            end
         end
         CMD_POP_FRONT, CMD_POP_REAR: begin
            if (empty_ff) begin
               status_in = STATUS_EMPTY;
            end else begin
               rd_en     = 1'b1;
               pop_ok_in = 1'b1;
               slot      = (cmd_ff == CMD_POP_FRONT) ? front_ff : rear_ff;
               if (front_ff == rear_ff) begin
                  // last entry leaves: reset both pointers
                  front_in = '0;
                  rear_in  = '0;
                  empty_in = 1'b1;
               end else if (cmd_ff == CMD_POP_FRONT) begin
                  front_in = wrap_next(front_ff);
               end else begin
                  rear_in = wrap_prev(rear_ff);
               end
            end
         end
      endcase
   end

   // Advance pointers on execute
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (ctrl.exec) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         empty_ff <= empty_in;
      end
   end

   // Hold the step outcome for the response cycle
   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
      end
   end

   // Store: one write or one registered read per step
   always_ff @(posedge clock) begin
      if (ctrl.exec && wr_en) begin
         mem[slot] <= val_ff;
      end
      if (ctrl.exec && rd_en) begin
         rdata_ff <= mem[slot];
      end
   end

   // Drive the result from the updated state
   always_comb begin
      rsp_data.popped_value = pop_ok_ff ? rdata_ff : '0;
      rsp_data.status       = status_ff;
      rsp_data.is_empty     = empty_ff;
      rsp_data.is_full      = full_now;
   end

endmodule
`default_nettype wire

[hw/rtl/cdq_ctrl.sv]
`default_nettype none
module cdq_ctrl (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   output logic             rsp_valid,
   output cdq_pkg::ctrl_type ctrl
);
   import cdq_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence capture, execute, respond
   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      busy         = 1'b1;
      rsp_valid    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctrl.exec = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            ctrl.respond = 1'b1;
            rsp_valid    = 1'b1;
            // take the next command at the edge that ends the response
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = ST_EXEC;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[hw/rtl/circular_deque_top.sv]
`default_nettype none
// Double-ended queue of 16 signed 32-bit words in a circular store. A command
// (push front, push rear, pop front, pop rear) transfers when start is high and
// busy is low. The cycle after the transfer edge does the store access (one
// write or one registered read); in the cycle after that the result is on
// rsp_data with rsp_valid high, and it is taken at the edge that ends it. Busy
// is low in that response cycle, so the next command may transfer at the same
// edge. Back to back, each command runs the sequence execute, respond.
// The receiver cannot stall: take the result in the cycle rsp_valid is high.
// A push into a full queue returns status full, a pop from an empty queue
// returns status empty; both leave the queue unchanged and report zero data.
module circular_deque_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire cdq_pkg::req_type req_data,
   output logic                  rsp_valid,
   output cdq_pkg::rsp_type      rsp_data
);
   import cdq_pkg::*;

   ctrl_type ctrl;
   logic     ctrl_busy;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (ctrl_busy),
      .rsp_valid (rsp_valid),
      .ctrl      (ctrl)
   );

   cdq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // Release busy in the response cycle so the next command can transfer
   assign busy = ctrl_busy && !ctrl.respond;

endmodule
`default_nettype wire

[hw/rtl/cdq_checker.sv]
`default_nettype none
`include "circular_deque_top_assert.svh"
module cdq_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire cdq_pkg::rsp_type rsp_data
);
   import cdq_pkg::*;

   // Every transfer is followed by its result with rsp_valid high
   `CDQ_ASSERT_SAME(a_result_follows, clock, reset, start && !busy, ##2 rsp_valid, "missing result")

   // A transfer makes the block busy for the next cycle
   `CDQ_ASSERT_NEXT(a_busy_after, clock, reset, start && !busy, busy, "not busy after transfer")

   // The strobe lasts a single cycle
   `CDQ_ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_valid, !rsp_valid, "strobe held")

   // A refused pop reports an empty queue and zero data
   `CDQ_ASSERT_SAME(a_refused_pop, clock, reset, rsp_valid && rsp_data.status == STATUS_EMPTY, rsp_data.is_empty && !rsp_data.is_full && rsp_data.popped_value == '0, "bad refused pop")

endmodule

bind circular_deque_top cdq_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire

[tb/cdq_compare.sv]
`default_nettype none
// Watches both channels of the deque, models the queue contents and
// compares every result against the modeled outcome of its command.
module cdq_compare
   import cdq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending,
   output int           result_count,
   output int           full_refusals,
   output int           empty_refusals
);

   // Modeled queue state
   logic signed [WORD_W-1:0] slots [DEPTH];
   logic [IDX_W-1:0]         head_idx;
   logic [IDX_W-1:0]         tail_idx;
   logic                     deque_empty;

   rsp_type outcomes[$];

   function automatic logic [IDX_W-1:0] idx_next(logic [IDX_W-1:0] i);
      return (int'(i) + 1 >= DEPTH) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
   endfunction

   function automatic logic deque_full();
      return !deque_empty && idx_next(tail_idx) == head_idx;
   endfunction

   // Apply one command to the modeled queue and return its outcome
   function automatic rsp_type deque_step(req_type item);
      rsp_type          r;
      logic [IDX_W-1:0] slot;
      r = '0;
      r.status = STATUS_DONE;
      if (item.command == CMD_PUSH_FRONT || item.command == CMD_PUSH_REAR) begin
         if (deque_full()) begin
            r.status = STATUS_FULL;
         end else begin
            if (deque_empty) begin
               head_idx = '0;
               tail_idx = '0;
               deque_empty = 1'b0;
               slot = '0;
            end else if (item.command == CMD_PUSH_FRONT) begin
               head_idx = idx_prev(head_idx);
               slot = head_idx;
            end else begin
               tail_idx = idx_next(tail_idx);
               slot = tail_idx;
            end
            slots[slot] = item.value;
         end
      end else begin
         if (deque_empty) begin
            r.status = STATUS_EMPTY;
         end else begin
            slot = (item.command == CMD_POP_FRONT) ? head_idx : tail_idx;
            r.popped_value = slots[slot];
            // last entry leaves: collapse both ends to slot zero
            if (head_idx == tail_idx) begin
               head_idx = '0;
               tail_idx = '0;
               deque_empty = 1'b1;
            end else if (item.command == CMD_POP_FRONT) begin
               head_idx = idx_next(head_idx);
            end else begin
               tail_idx = idx_prev(tail_idx);
            end
         end
      end
      r.is_empty = deque_empty;
      r.is_full = deque_full();
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      int      errs;
      errs = 0;
      if (reset) begin
         head_idx = '0;
         tail_idx = '0;
         deque_empty = 1'b1;
         outcomes.delete();
         fail_count <= 0;
         result_count <= 0;
         full_refusals <= 0;
         empty_refusals <= 0;
      end else begin
         // compare the result transfer against the oldest outcome
         if (rsp_valid) begin
            got = rsp_data;
            if (outcomes.size() == 0) begin
               $error("result with no command outstanding: %h", got);
               errs++;
            end else begin
               want = outcomes.pop_front();
               result_count <= result_count + 1;
               if (got.popped_value !== want.popped_value) begin
                  $error("popped_value expected %0d got %0d",
                         want.popped_value, got.popped_value);
                  errs++;
               end
               if (got.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, got.status);
                  errs++;
               end
               if (got.is_empty !== want.is_empty) begin
                  $error("is_empty expected %0d got %0d", want.is_empty, got.is_empty);
                  errs++;
               end
               if (got.is_full !== want.is_full) begin
                  $error("is_full expected %0d got %0d", want.is_full, got.is_full);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         // model each command transfer
         if (start && !busy) begin
            want = deque_step(req_data);
            outcomes.push_back(want);
            if (want.status == STATUS_FULL)
               full_refusals <= full_refusals + 1;
            if (want.status == STATUS_EMPTY)
               empty_refusals <= empty_refusals + 1;
         end
      end
      pending <= outcomes.size();
   end

endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
   import cdq_pkg::*;

   localparam int RANDOM_CMDS = 1225;
   localparam int QUIET_TAIL = 200;
   localparam int STALL_LIMIT = 1000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int result_count;
   int full_refusals;
   int empty_refusals;
   int stall_cycles;

   circular_deque_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   cdq_compare u_compare (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .result_count   (result_count),
      .full_refusals  (full_refusals),
      .empty_refusals (empty_refusals)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // End the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("circular_deque_top verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Present one command and hold it until it transfers
   task automatic send_cmd(cmd_type cmd, logic signed [WORD_W-1:0] word);
      start <= 1'b1;
      req_data <= '{command: cmd, value: word};
      do @(posedge clock); while (busy);
   endtask

   // Drop start for a random burst of cycles
   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clock);
   endtask

   // Hold off until every outstanding result has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 15))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'sh0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int push_pct;
      int mode_left;
      int idle_pct;
      int chunk_left;
      logic is_push;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: refusals on empty, single-entry round trips at both ends
      send_cmd(CMD_POP_FRONT, 32'sh1234_5678);
      send_cmd(CMD_POP_REAR, -32'sd1);
      send_cmd(CMD_PUSH_FRONT, 32'sh7fff_ffff);
      send_cmd(CMD_POP_REAR, 32'sh0);
      send_cmd(CMD_PUSH_REAR, 32'sh8000_0000);
      send_cmd(CMD_POP_FRONT, 32'sh0);
      // Fill from both ends so the head wraps below slot zero
      for (int i = 0; i < DEPTH; i++)
         send_cmd((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, $urandom);
      send_cmd(CMD_PUSH_FRONT, -32'sd1);
      send_cmd(CMD_PUSH_REAR, 32'sh5555_aaaa);
      drain();

      // Random: switch among fill-heavy, drain-heavy and balanced stretches
      push_pct = 50;
      mode_left = 0;
      idle_pct = 0;
      chunk_left = 0;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (mode_left == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 80;
               1: push_pct = 20;
               default: push_pct = 50;
            endcase
            mode_left = $urandom_range(10, 40);
         end
         mode_left--;
         if (chunk_left == 0) begin
            idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            chunk_left = $urandom_range(20, 80);
         end
         chunk_left--;

         is_push = ($urandom_range(0, 99) < push_pct);
         if (is_push)
            send_cmd($urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, pick_word());
         else
            send_cmd($urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT, pick_word());

         if (n % 300 == 299)
            drain();
         else if (n < RANDOM_CMDS - QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
            idle_burst();
      end

      drain();
      repeat (10) @(posedge clock);

      $display("Checked %0d deque results over push and pop at both ends,",
               result_count);
      $display("including %0d full-queue and %0d empty-queue refusals.",
               full_refusals, empty_refusals);
      if (fail_count == 0) begin
         $display("circular_deque_top verification clean");
      end else begin
         $display("circular_deque_top verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_datapath.sv
hw/rtl/cdq_ctrl.sv
hw/rtl/circular_deque_top.sv
hw/rtl/cdq_checker.sv
tb/cdq_compare.sv
tb/tb_top.sv
